// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by first_fit_heap_allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/ffha_pkg.sv -----
// shared types and constants of the first-fit heap allocator
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int HEAP_BYTES_DEF   = 1024;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int REQ_W            = 10;
    localparam int OFF_W            = 10;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC_WALK,
        ST_MARK,
        ST_SPLIT_HEAD,
        ST_SPLIT_REST,
        ST_FREE_WALK,
        ST_MERGE_WALK,
        ST_MERGE_WRITE,
        ST_RESP
    } state_t;

    typedef enum logic {
        ALU_NEXT,
        ALU_GAP
    } alu_op_t;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [OFF_W-1:0] payload_offset;
    } resp_t;

endpackage

// ----- hw/rtl/ffha_if.sv -----
// valid/ready channel interfaces of the allocator
`timescale 1ns / 1ps

interface ffha_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [ffha_pkg::REQ_W-1:0] request_size;
    logic [ffha_pkg::OFF_W-1:0] free_offset;

    modport source (output valid, output mode, output request_size, output free_offset,
                    input ready);
    modport sink (input valid, input mode, input request_size, input free_offset,
                  output ready);
endinterface

interface ffha_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic [ffha_pkg::OFF_W-1:0] payload_offset;

    modport source (output valid, output ok, output payload_offset, input ready);
    modport sink (input valid, input ok, input payload_offset, output ready);
endinterface

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// one word at a time: the next is taken in idle, delayed while the output register is full
// allocate: headers read, then the header write (also the leftover one on a split, none on
// failure) and the response; free: headers read up to its block, the free headers after it
// and the used header that ends them, the merged header write and the response; an ignored
// free writes no header before its response
// reset: async active low, heap holds one free block spanning it, no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp
);
    import ffha_pkg::*;

    // address widths: positions run up to the heap end, sizes stay below it
    localparam int AW = $clog2(HEAP_BYTES);
    localparam int PW = $clog2(HEAP_BYTES + 1);
    localparam int SW = AW;
    localparam int CW = ((PW > REQ_W) ? PW : REQ_W) + 2;

    // header word: allocated mark on top, payload size below
    localparam logic [SW:0] INIT_WORD = {1'b0, SW'(HEAP_BYTES - HEADER_BYTES)};

    logic          idle;
    logic          in_fire;
    logic          slot_free;
    resp_t         resp;

    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [SW:0]   mem_wdata;
    logic [PW-1:0] mem_raddr;
    logic [SW:0]   mem_rdata;

    alu_op_t       alu_op;
    logic [CW-1:0] alu_a;
    logic [CW-1:0] alu_b;
    logic [CW-1:0] alu_res;

    logic             out_valid_reg;
    logic             out_ok_reg;
    logic [OFF_W-1:0] out_off_reg;

    // input side: a word is taken whenever the sequencer is idle
    assign req.ready = idle;
    assign in_fire   = req.valid && req.ready;

    // output register frees when empty or when its word is being taken
    assign slot_free = !out_valid_reg || rsp.ready;

    // sequencer: walks the header chain one header per cycle
    ffha_ctrl #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .PW           (PW),
        .SW           (SW),
        .CW           (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_fire),
        .mode         (req.mode),
        .request_size (req.request_size),
        .free_offset  (req.free_offset),
        .idle         (idle),
        .resp         (resp),
        .resp_take    (slot_free),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .alu_op       (alu_op),
        .alu_a        (alu_a),
        .alu_b        (alu_b),
        .alu_res      (alu_res)
    );

    // the one adder shared by walk, split, merge and offset computation
    ffha_alu #(
        .W            (CW),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // one header slot per heap byte; only block starts are ever read
    ffha_hdr_mem #(
        .DEPTH     (HEAP_BYTES),
        .DW        (SW + 1),
        .INIT_WORD (INIT_WORD)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr[AW-1:0]),
        .wdata (mem_wdata),
        .raddr (mem_raddr[AW-1:0]),
        .rdata (mem_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (resp.valid && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp.valid && slot_free)
        begin
            out_ok_reg  <= resp.ok;
            out_off_reg <= resp.payload_offset;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.payload_offset = out_off_reg;

    // a taken word keeps the sequencer busy for at least the next cycle
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_fire, !req.ready, "ready right after a take")
    // header writes stay inside the heap
    `ASSERT_IMPL(a_write_in_heap, clk, rst_n, mem_we,
                 mem_waddr < PW'(HEAP_BYTES), "header write past heap end")
    // failed results never carry an offset
    `ASSERT_IMPL(a_fail_zero_off, clk, rst_n, resp.valid && !resp.ok,
                 resp.payload_offset == '0, "offset on failure")

endmodule

// ----- hw/rtl/ffha_hdr_mem.sv -----
// block header memory, one write and one registered read port
`timescale 1ns / 1ps

module ffha_hdr_mem #(
    parameter int          DEPTH     = ffha_pkg::HEAP_BYTES_DEF,
    parameter int          DW        = 11,
    parameter logic [DW-1:0] INIT_WORD = '0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);
    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;
    logic          init_pend_reg;
    logic          init_sel_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // entry zero reads as the single free block until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_pend_reg <= 1'b1;
            init_sel_reg  <= 1'b0;
        end
        else
        begin
            if (we && (waddr == AW'(0)))
            begin
                init_pend_reg <= 1'b0;
            end
            init_sel_reg <= init_pend_reg && (raddr == AW'(0));
        end
    end

    assign rdata = init_sel_reg ? INIT_WORD : rdata_reg;

endmodule

// ----- hw/rtl/ffha_alu.sv -----
// shared pointer arithmetic unit: next block start and gap size
`timescale 1ns / 1ps

module ffha_alu #(
    parameter int W            = 12,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  ffha_pkg::alu_op_t op,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic [W-1:0]      res
);
    import ffha_pkg::*;

    always_comb
    begin
        unique case (op)
            ALU_NEXT: res = a + b + W'(HEADER_BYTES);
            ALU_GAP:  res = a - b - W'(HEADER_BYTES);
            default:  res = '0;
        endcase
    end

endmodule

// ----- hw/rtl/ffha_ctrl.sv -----
// sequencer that walks the header chain for allocate and free
`timescale 1ns / 1ps

module ffha_ctrl #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int PW           = $clog2(HEAP_BYTES + 1),
    parameter int SW           = $clog2(HEAP_BYTES),
    parameter int CW           = ((PW > ffha_pkg::REQ_W) ? PW : ffha_pkg::REQ_W) + 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       mode,
    input  logic [ffha_pkg::REQ_W-1:0] request_size,
    input  logic [ffha_pkg::OFF_W-1:0] free_offset,
    output logic                       idle,
    output ffha_pkg::resp_t            resp,
    input  logic                       resp_take,
    output logic                       mem_we,
    output logic [PW-1:0]              mem_waddr,
    output logic [SW:0]                mem_wdata,
    output logic [PW-1:0]              mem_raddr,
    input  logic [SW:0]                mem_rdata,
    output ffha_pkg::alu_op_t          alu_op,
    output logic [CW-1:0]              alu_a,
    output logic [CW-1:0]              alu_b,
    input  logic [CW-1:0]              alu_res
);
    import ffha_pkg::*;

    state_t           state_reg, state_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    aux_reg, aux_next;
    logic [PW-1:0]    run_start_reg, run_start_next;
    logic             prev_free_reg, prev_free_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic [OFF_W-1:0] target_reg, target_next;
    logic [SW-1:0]    size_reg, size_next;
    logic             mode_reg, mode_next;
    logic             ok_reg, ok_next;

    logic             rd_mark;
    logic [SW-1:0]    rd_size;
    logic             next_end;
    logic             fit;
    logic             split;
    logic             hit;
    logic             low_off;
    logic [PW-1:0]    next_pos;

    assign rd_mark  = mem_rdata[SW];
    assign rd_size  = mem_rdata[SW-1:0];
    assign next_pos = alu_res[PW-1:0];
    assign next_end = alu_res >= CW'(HEAP_BYTES);
    assign fit      = !rd_mark && (CW'(rd_size) >= CW'(req_reg));
    assign split    = CW'(rd_size) > (CW'(req_reg) + CW'(HEADER_BYTES));
    assign hit      = CW'(pos_reg) == CW'(target_reg);
    assign low_off  = free_offset < OFF_W'(HEADER_BYTES);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_ALLOC)
                    begin
                        state_next = ST_ALLOC_WALK;
                    end
                    else if (low_off)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_FREE_WALK;
                    end
                end
            end
            ST_ALLOC_WALK:
            begin
                if (fit)
                begin
                    state_next = split ? ST_SPLIT_HEAD : ST_MARK;
                end
                else if (next_end)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_MARK:        state_next = ST_RESP;
            ST_SPLIT_HEAD:  state_next = ST_SPLIT_REST;
            ST_SPLIT_REST:  state_next = ST_RESP;
            ST_FREE_WALK:
            begin
                if (hit)
                begin
                    state_next = next_end ? ST_MERGE_WRITE : ST_MERGE_WALK;
                end
                else if (next_end)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_MERGE_WALK:
            begin
                if (rd_mark || next_end)
                begin
                    state_next = ST_MERGE_WRITE;
                end
            end
            ST_MERGE_WRITE: state_next = ST_RESP;
            ST_RESP:
            begin
                if (resp_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pos_next       = pos_reg;
        aux_next       = aux_reg;
        run_start_next = run_start_reg;
        prev_free_next = prev_free_reg;
        req_next       = req_reg;
        target_next    = target_reg;
        size_next      = size_reg;
        mode_next      = mode_reg;
        ok_next        = ok_reg;
        idle           = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = {1'b0, size_reg};
        mem_raddr      = pos_reg;
        alu_op         = ALU_NEXT;
        alu_a          = CW'(pos_reg);
        alu_b          = CW'(rd_size);
        resp.valid     = 1'b0;
        resp.ok        = ok_reg;
        resp.payload_offset = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                idle      = 1'b1;
                mem_raddr = '0;
                if (start)
                begin
                    pos_next       = '0;
                    run_start_next = '0;
                    prev_free_next = 1'b0;
                    req_next       = request_size;
                    target_next    = free_offset - OFF_W'(HEADER_BYTES);
                    mode_next      = mode;
                    ok_next        = 1'b0;
                end
            end
            ST_ALLOC_WALK:
            begin
                if (fit)
                begin
                    size_next = rd_size;
                    ok_next   = 1'b1;
                end
                else if (!next_end)
                begin
                    pos_next  = next_pos;
                    mem_raddr = next_pos;
                end
            end
            ST_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, size_reg};
            end
            ST_SPLIT_HEAD:
            begin
                // alu gives the start of the leftover block
                mem_we    = 1'b1;
                mem_wdata = {1'b1, SW'(req_reg)};
                alu_b     = CW'(req_reg);
                aux_next  = next_pos;
            end
            ST_SPLIT_REST:
            begin
                alu_op    = ALU_GAP;
                alu_a     = CW'(size_reg);
                alu_b     = CW'(req_reg);
                mem_we    = 1'b1;
                mem_waddr = aux_reg;
                mem_wdata = {1'b0, alu_res[SW-1:0]};
            end
            ST_FREE_WALK:
            begin
                if (hit)
                begin
                    aux_next = prev_free_reg ? run_start_reg : pos_reg;
                    if (next_end)
                    begin
                        pos_next = PW'(HEAP_BYTES);
                    end
                    else
                    begin
                        pos_next  = next_pos;
                        mem_raddr = next_pos;
                    end
                end
                else
                begin
                    if (rd_mark)
                    begin
                        prev_free_next = 1'b0;
                    end
                    else
                    begin
                        if (!prev_free_reg)
                        begin
                            run_start_next = pos_reg;
                        end
                        prev_free_next = 1'b1;
                    end
                    if (!next_end)
                    begin
                        pos_next  = next_pos;
                        mem_raddr = next_pos;
                    end
                end
            end
            ST_MERGE_WALK:
            begin
                // pos stops on the first allocated block or the heap end
                if (!rd_mark)
                begin
                    if (next_end)
                    begin
                        pos_next = PW'(HEAP_BYTES);
                    end
                    else
                    begin
                        pos_next  = next_pos;
                        mem_raddr = next_pos;
                    end
                end
            end
            ST_MERGE_WRITE:
            begin
                alu_op    = ALU_GAP;
                alu_a     = CW'(pos_reg);
                alu_b     = CW'(aux_reg);
                mem_we    = 1'b1;
                mem_waddr = aux_reg;
                mem_wdata = {1'b0, alu_res[SW-1:0]};
                ok_next   = 1'b1;
            end
            ST_RESP:
            begin
                // alu gives block start plus header
                alu_b      = '0;
                resp.valid = 1'b1;
                if (ok_reg && (mode_reg == MODE_ALLOC))
                begin
                    resp.payload_offset = alu_res[OFF_W-1:0];
                end
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        aux_reg       <= aux_next;
        run_start_reg <= run_start_next;
        prev_free_reg <= prev_free_next;
        req_reg       <= req_next;
        target_reg    <= target_next;
        size_reg      <= size_next;
        mode_reg      <= mode_next;
        ok_reg        <= ok_next;
    end

endmodule
